@@ hw/rtl/timed_task_scheduler_defines.svh @@
// ---------------------------------------------------------------------------
// Timed task scheduler assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef TIMED_TASK_SCHEDULER_DEFINES_SVH
`define TIMED_TASK_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define TTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tts check failed");
`define TTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tts check failed");
`else
`define TTS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/tts_pkg.sv @@
// ---------------------------------------------------------------------------
// Timed task scheduler package
// Beat types, command, result, status and entry kind codes, sequencer states and phases.
// ---------------------------------------------------------------------------
package tts_pkg;

    typedef struct packed {
        logic [2:0]  func;
        logic [30:0] time_value;
        logic [15:0] task_handle;
        logic [31:0] user_word;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] fired_handle;
        logic [31:0] argument;
        logic [1:0]  status;
        logic        last;
    } t_out_beat;

    localparam logic [2:0] FUNC_TICK      = 3'd0;
    localparam logic [2:0] FUNC_ADD_PER   = 3'd1;
    localparam logic [2:0] FUNC_ADD_ONE   = 3'd2;
    localparam logic [2:0] FUNC_ADD_FRAME = 3'd3;
    localparam logic [2:0] FUNC_REMOVE    = 3'd4;
    localparam logic [2:0] FUNC_RESCHED   = 3'd5;

    localparam logic [2:0] RES_PERIODIC = 3'd0;
    localparam logic [2:0] RES_ONESHOT  = 3'd1;
    localparam logic [2:0] RES_FRAME    = 3'd2;
    localparam logic [2:0] RES_ACK      = 3'd3;
    localparam logic [2:0] RES_DONE     = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_DEFERRED  = 2'd3;

    localparam logic [1:0] EK_PERIODIC = 2'd0;
    localparam logic [1:0] EK_ONESHOT  = 2'd1;
    localparam logic [1:0] EK_FRAME    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        PH_ADD,
        PH_FIND,
        PH_DEC,
        PH_TIMED,
        PH_FRAME
    } t_phase;

endpackage

@@ hw/rtl/tts_ram.sv @@
// ---------------------------------------------------------------------------
// Timed task scheduler RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hw/rtl/timed_task_scheduler.sv @@
// ---------------------------------------------------------------------------
// Timed task scheduler
// Table of periodic, one-shot and per-frame timers with tick processing.
// ---------------------------------------------------------------------------
// Usage:
//   Command beats enter on i_in_valid / o_in_stall; result beats leave on
//   o_out_valid / i_out_stall, the final beat of each known command has last set.
//   One command is worked at a time; o_in_stall is high until its final
//   beat sits in the output register.
//   Every pass over the table reads one entry per cycle from the entry RAM,
//   then waits in S_DRAIN for the last read and decides in S_DECIDE.
//   Add, remove, reschedule: one pass.
//   Tick: one pass to age the deadlines, one pass per timed firing plus one
//   to stop, one pass per frame firing, then the done beat.
//   A stalled output register holds the sequencer at its next result.
//   Reset clears the valid bits, the handle and stamp counters and the
//   output valid flag; the block is ready in the cycle after reset.
// ---------------------------------------------------------------------------
`include "timed_task_scheduler_defines.svh"

module timed_task_scheduler #(
    parameter int TABLE_ENTRIES = 16,
    parameter int MAX_RESULTS   = 64,
    parameter int TIME_WIDTH    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tts_pkg::t_in_beat  i_in_beat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tts_pkg::t_out_beat o_out_beat
);

    import tts_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int DW = TIME_WIDTH + 1;
    localparam int FW = $clog2(TABLE_ENTRIES + 1);
    localparam int RW = $clog2(MAX_RESULTS);
    localparam int CW = (FW > RW) ? FW : RW;
    localparam logic [CW-1:0] SLOTS    = CW'(MAX_RESULTS - 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
    localparam logic [63:0]   TMAX64   = (64'd1 << TIME_WIDTH) - 64'd1;
    localparam logic [DW-1:0] DL_MIN   = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic [15:0]          handle;
        logic [1:0]           kind;
        logic signed [DW-1:0] deadline;
        logic [30:0]          period;
        logic [31:0]          user;
        logic [15:0]          stamp;
    } t_entry;

    t_state  r_state, n_state;
    t_phase  r_phase, n_phase;
    t_in_beat r_cmd, n_cmd;
    logic [30:0] r_tv, n_tv;
    logic [IW-1:0] r_idx, n_idx, r_ridx, n_ridx, r_bidx, n_bidx;
    logic r_rv, n_rv, r_found, n_found;
    t_entry r_best, n_best;
    logic [15:0] r_bage, n_bage;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid, r_done, n_done;
    logic [15:0] r_handle, n_handle, r_stamp, n_stamp;
    logic [FW-1:0] r_frames, n_frames;
    logic [RW-1:0] r_fslots, n_fslots, r_tslots, n_tslots, r_n, n_n, r_fcount, n_fcount;
    logic r_defer, n_defer, r_fdefer, n_fdefer;
    logic r_ov, n_ov;
    t_out_beat r_out, n_out;

    t_entry w_rd, w_wdata;
    logic w_we, w_emit, w_can_put, w_v, w_better;
    logic [IW-1:0] w_waddr;
    logic [15:0] w_age;
    logic [DW:0] w_diff;
    logic [DW-1:0] w_dec;
    logic [30:0] w_per, w_tv_cl;
    logic [CW-1:0] w_fsl;

    tts_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(TABLE_ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_idx),
        .o_rdata(w_rd)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_beat  = r_out;
    assign w_can_put   = !r_ov || !i_out_stall;

    assign w_v     = r_valid[r_ridx];
    assign w_age   = r_stamp - w_rd.stamp;
    assign w_diff  = {w_rd.deadline[DW-1], w_rd.deadline} - (DW+1)'(64'(r_tv));
    assign w_dec   = (w_diff[DW] != w_diff[DW-1]) ? DL_MIN : w_diff[DW-1:0];
    assign w_per   = (r_tv == 31'd0) ? 31'd1 : r_tv;
    assign w_tv_cl = (64'(i_in_beat.time_value) > TMAX64) ? 31'(TMAX64)
                                                           : i_in_beat.time_value;
    assign w_fsl   = (CW'(r_frames) < SLOTS) ? CW'(r_frames) : SLOTS;
    assign w_better = ($signed(w_rd.deadline) < $signed(r_best.deadline)) ||
                      ((w_rd.deadline == r_best.deadline) && (w_age < r_bage));

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_tv     = r_tv;
        n_idx    = r_idx;
        n_ridx   = r_ridx;
        n_rv     = 1'b0;
        n_found  = r_found;
        n_bidx   = r_bidx;
        n_best   = r_best;
        n_bage   = r_bage;
        n_valid  = r_valid;
        n_done   = r_done;
        n_handle = r_handle;
        n_stamp  = r_stamp;
        n_frames = r_frames;
        n_fslots = r_fslots;
        n_tslots = r_tslots;
        n_n      = r_n;
        n_fcount = r_fcount;
        n_defer  = r_defer;
        n_fdefer = r_fdefer;
        n_out    = r_out;
        w_emit   = 1'b0;
        w_we     = 1'b0;
        w_waddr  = r_bidx;
        w_wdata  = r_best;

        // entry read back from the previous scan address
        if (r_rv) begin
            unique case (r_phase)
                PH_ADD: begin
                    if (!r_found && !w_v) begin
                        n_found = 1'b1;
                        n_bidx  = r_ridx;
                    end
                end
                PH_FIND: begin
                    if (!r_found && w_v && (w_rd.handle == r_cmd.task_handle)) begin
                        n_found = 1'b1;
                        n_bidx  = r_ridx;
                        n_best  = w_rd;
                    end
                end
                PH_DEC: begin
                    if (w_v) begin
                        if (w_rd.kind == EK_FRAME) begin
                            n_frames = r_frames + 1'b1;
                        end else begin
                            w_we             = 1'b1;
                            w_waddr          = r_ridx;
                            w_wdata          = w_rd;
                            w_wdata.deadline = w_dec;
                        end
                    end
                end
                PH_TIMED: begin
                    if (w_v && (w_rd.kind != EK_FRAME) && (!r_found || w_better)) begin
                        n_found = 1'b1;
                        n_bidx  = r_ridx;
                        n_best  = w_rd;
                        n_bage  = w_age;
                    end
                end
                PH_FRAME: begin
                    if (w_v && (w_rd.kind == EK_FRAME) && !r_done[r_ridx] &&
                        (!r_found || (w_age < r_bage))) begin
                        n_found = 1'b1;
                        n_bidx  = r_ridx;
                        n_best  = w_rd;
                        n_bage  = w_age;
                    end
                end
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_beat;
                    n_tv    = w_tv_cl;
                    n_idx   = '0;
                    n_found = 1'b0;
                    priority case (i_in_beat.func)
                        FUNC_TICK: begin
                            n_phase  = PH_DEC;
                            n_frames = '0;
                            n_state  = S_SCAN;
                        end
                        FUNC_ADD_PER, FUNC_ADD_ONE, FUNC_ADD_FRAME: begin
                            n_phase = PH_ADD;
                            n_state = S_SCAN;
                        end
                        FUNC_REMOVE, FUNC_RESCHED: begin
                            n_phase = PH_FIND;
                            n_state = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                n_rv   = 1'b1;
                n_ridx = r_idx;
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (w_can_put) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_out.argument = '0;
                    n_out.status   = ST_OK;
                    n_out.last     = 1'b0;
                    unique case (r_phase)
                        PH_ADD: begin
                            w_emit             = 1'b1;
                            n_out.kind         = RES_ACK;
                            n_out.last         = 1'b1;
                            n_state            = S_IDLE;
                            if (!r_found) begin
                                n_out.fired_handle = '0;
                                n_out.status       = ST_FULL;
                            end else begin
                                n_out.fired_handle = r_handle;
                                w_we             = 1'b1;
                                w_wdata.handle   = r_handle;
                                w_wdata.stamp    = r_stamp;
                                w_wdata.deadline = '0;
                                w_wdata.period   = '0;
                                w_wdata.user     = '0;
                                priority case (r_cmd.func)
                                    FUNC_ADD_PER: begin
                                        w_wdata.kind   = EK_PERIODIC;
                                        w_wdata.period = w_per;
                                    end
                                    FUNC_ADD_ONE: begin
                                        w_wdata.kind     = EK_ONESHOT;
                                        w_wdata.deadline = DW'(64'(r_tv));
                                        w_wdata.user     = r_cmd.user_word;
                                    end
                                    default: w_wdata.kind = EK_FRAME;
                                endcase
                                n_valid[r_bidx] = 1'b1;
                                n_stamp  = r_stamp + 16'd1;
                                n_handle = r_handle + 16'd1;
                            end
                        end
                        PH_FIND: begin
                            w_emit             = 1'b1;
                            n_out.kind         = RES_ACK;
                            n_out.fired_handle = r_cmd.task_handle;
                            n_out.last         = 1'b1;
                            n_state            = S_IDLE;
                            if (!r_found) begin
                                n_out.status = ST_NOT_FOUND;
                            end else if (r_cmd.func == FUNC_REMOVE) begin
                                if (r_best.kind == EK_ONESHOT) begin
                                    n_out.argument = r_best.user;
                                end
                                n_valid[r_bidx] = 1'b0;
                            end else if (r_best.kind == EK_PERIODIC) begin
                                w_we           = 1'b1;
                                w_wdata.period = w_per;
                            end else if (r_best.kind == EK_ONESHOT) begin
                                w_we             = 1'b1;
                                w_wdata.deadline = DW'(64'(r_tv));
                                w_wdata.stamp    = r_stamp;
                                n_stamp          = r_stamp + 16'd1;
                            end
                        end
                        PH_DEC: begin
                            n_fslots = RW'(w_fsl);
                            n_tslots = RW'(SLOTS - w_fsl);
                            n_fdefer = (CW'(r_frames) > SLOTS);
                            n_defer  = 1'b0;
                            n_n      = '0;
                            n_phase  = PH_TIMED;
                            n_state  = S_SCAN;
                        end
                        PH_TIMED: begin
                            if (!r_found || !r_best.deadline[DW-1] || (r_n >= r_tslots)) begin
                                n_defer  = r_found && r_best.deadline[DW-1];
                                n_done   = '0;
                                n_fcount = '0;
                                n_phase  = PH_FRAME;
                                n_state  = (r_fslots == '0) ? S_DONE : S_SCAN;
                            end else begin
                                w_emit             = 1'b1;
                                n_out.fired_handle = r_best.handle;
                                n_n                = r_n + 1'b1;
                                n_state            = S_SCAN;
                                if (r_best.kind == EK_PERIODIC) begin
                                    n_out.kind       = RES_PERIODIC;
                                    n_out.argument   = 32'(r_best.period);
                                    w_we             = 1'b1;
                                    w_wdata.deadline = r_best.deadline + DW'(r_best.period);
                                    w_wdata.stamp    = r_stamp;
                                    n_stamp          = r_stamp + 16'd1;
                                end else begin
                                    n_out.kind      = RES_ONESHOT;
                                    n_out.argument  = r_best.user;
                                    n_valid[r_bidx] = 1'b0;
                                end
                            end
                        end
                        PH_FRAME: begin
                            if (!r_found) begin
                                n_state = S_DONE;
                            end else begin
                                w_emit             = 1'b1;
                                n_out.kind         = RES_FRAME;
                                n_out.fired_handle = r_best.handle;
                                n_out.argument     = 32'(r_tv);
                                n_done[r_bidx]     = 1'b1;
                                n_fcount           = r_fcount + 1'b1;
                                n_state = (((RW+1)'(r_fcount) + 1'b1) < (RW+1)'(r_fslots))
                                          ? S_SCAN : S_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DONE: begin
                if (w_can_put) begin
                    w_emit             = 1'b1;
                    n_out.kind         = RES_DONE;
                    n_out.fired_handle = '0;
                    n_out.argument     = '0;
                    n_out.status       = (r_defer || r_fdefer) ? ST_DEFERRED : ST_OK;
                    n_out.last         = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_ov = w_emit || (r_ov && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_ADD;
            r_rv     <= 1'b0;
            r_valid  <= '0;
            r_handle <= '0;
            r_stamp  <= '0;
            r_ov     <= 1'b0;
            r_n      <= '0;
            r_tslots <= '0;
            r_fcount <= '0;
            r_fslots <= '0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_rv     <= n_rv;
            r_valid  <= n_valid;
            r_handle <= n_handle;
            r_stamp  <= n_stamp;
            r_ov     <= n_ov;
            r_n      <= n_n;
            r_tslots <= n_tslots;
            r_fcount <= n_fcount;
            r_fslots <= n_fslots;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_tv     <= n_tv;
        r_idx    <= n_idx;
        r_ridx   <= n_ridx;
        r_found  <= n_found;
        r_bidx   <= n_bidx;
        r_best   <= n_best;
        r_bage   <= n_bage;
        r_done   <= n_done;
        r_frames <= n_frames;
        r_defer  <= n_defer;
        r_fdefer <= n_fdefer;
        r_out    <= n_out;
    end

    `TTS_ASSERT_SAME(a_timed_limit, i_clk, i_rst_n, r_phase == PH_TIMED, r_n <= r_tslots)
    `TTS_ASSERT_SAME(a_frame_limit, i_clk, i_rst_n, r_phase == PH_FRAME, r_fcount <= r_fslots)
    `TTS_ASSERT_SAME(a_ram_write, i_clk, i_rst_n, w_we,
                     (r_phase == PH_DEC) || (r_state == S_DECIDE))
    `TTS_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, w_emit && n_out.last, r_state == S_IDLE)

endmodule

@@ dv/tb.sv @@
// ---------------------------------------------------------------------------
// Timed task scheduler testbench
// Drives command beats and predicts every result beat with its own model of
// the timer table. Each result beat is checked field by field against the
// oldest prediction. Sender gaps and receiver stalls are random, except while quiet is set.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tts_pkg::*;

    localparam int  ENTRIES   = 16;
    localparam int  SLOTS     = 63;
    localparam int  WD_LIMIT  = 20000;
    localparam longint T_FLOOR = -(64'sd1 <<< 32);

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_beat   i_in_beat = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_beat  o_out_beat;

    timed_task_scheduler dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // scoreboard model of the timer table
    logic        tm_valid [ENTRIES];
    logic [15:0] tm_handle[ENTRIES];
    logic [1:0]  tm_kind  [ENTRIES];
    longint      tm_due   [ENTRIES];
    logic [31:0] tm_period[ENTRIES];
    logic [31:0] tm_user  [ENTRIES];
    logic [15:0] tm_stamp [ENTRIES];
    logic [15:0] handle_ctr;
    logic [15:0] stamp_ctr;

    t_out_beat   pending_beats[$];
    int          errors = 0;
    int          stall_left = 0;
    bit          quiet = 1'b0;
    int          idle_cycles = 0;

    function automatic logic [15:0] age(int i);
        return 16'(stamp_ctr - tm_stamp[i]);
    endfunction

    function automatic void push_beat(logic [2:0] k, logic [15:0] h, logic [31:0] a,
                                      logic [1:0] s, logic l);
        t_out_beat r;
        r.kind = k; r.fired_handle = h; r.argument = a; r.status = s; r.last = l;
        pending_beats = {pending_beats, r};
    endfunction

    function automatic int find_entry(logic [15:0] h);
        for (int i = 0; i < ENTRIES; i++)
            if (tm_valid[i] && tm_handle[i] == h) return i;
        return -1;
    endfunction

    function automatic void predict_tick(longint dt);
        bit          fired[ENTRIES];
        int          frames, fslots, tslots, n, b;
        logic [1:0]  st;
        frames = 0; n = 0; st = ST_OK;
        for (int i = 0; i < ENTRIES; i++) begin
            fired[i] = 1'b0;
            if (!tm_valid[i]) continue;
            if (tm_kind[i] == EK_FRAME) begin
                frames++;
                continue;
            end
            tm_due[i] -= dt;
            if (tm_due[i] < T_FLOOR) tm_due[i] = T_FLOOR;
        end
        fslots = frames < SLOTS ? frames : SLOTS;
        tslots = SLOTS - fslots;
        while (1) begin
            b = -1;
            for (int i = 0; i < ENTRIES; i++) begin
                if (!tm_valid[i] || tm_kind[i] == EK_FRAME) continue;
                if (b < 0 || tm_due[i] < tm_due[b] ||
                    (tm_due[i] == tm_due[b] && age(i) < age(b))) b = i;
            end
            if (b < 0 || tm_due[b] >= 0) break;
            if (n >= tslots) begin
                st = ST_DEFERRED;
                break;
            end
            n++;
            if (tm_kind[b] == EK_PERIODIC) begin
                push_beat(RES_PERIODIC, tm_handle[b], tm_period[b], ST_OK, 1'b0);
                tm_due[b] += longint'(tm_period[b]);
                tm_stamp[b] = stamp_ctr;
                stamp_ctr++;
            end else begin
                push_beat(RES_ONESHOT, tm_handle[b], tm_user[b], ST_OK, 1'b0);
                tm_valid[b] = 1'b0;
            end
        end
        for (int f = 0; f < fslots; f++) begin
            b = -1;
            for (int i = 0; i < ENTRIES; i++) begin
                if (!tm_valid[i] || tm_kind[i] != EK_FRAME || fired[i]) continue;
                if (b < 0 || age(i) < age(b)) b = i;
            end
            if (b < 0) break;
            fired[b] = 1'b1;
            push_beat(RES_FRAME, tm_handle[b], 32'(dt), ST_OK, 1'b0);
        end
        if (frames > fslots) st = ST_DEFERRED;
        push_beat(RES_DONE, 16'd0, 32'd0, st, 1'b1);
    endfunction

    function automatic void predict_command(t_in_beat c);
        int          e;
        logic [31:0] tv;
        tv = 32'(c.time_value);
        case (c.func)
            FUNC_TICK: predict_tick(longint'(tv));
            FUNC_ADD_PER, FUNC_ADD_ONE, FUNC_ADD_FRAME: begin
                e = -1;
                for (int i = ENTRIES - 1; i >= 0; i--) if (!tm_valid[i]) e = i;
                if (e < 0) begin
                    push_beat(RES_ACK, 16'd0, 32'd0, ST_FULL, 1'b1);
                end else begin
                    tm_valid[e] = 1'b1;
                    tm_handle[e] = handle_ctr;
                    tm_user[e] = '0;
                    tm_period[e] = '0;
                    tm_due[e] = 0;
                    if (c.func == FUNC_ADD_PER) begin
                        tm_kind[e] = EK_PERIODIC;
                        tm_period[e] = tv == 0 ? 32'd1 : tv;
                    end else if (c.func == FUNC_ADD_ONE) begin
                        tm_kind[e] = EK_ONESHOT;
                        tm_due[e] = longint'(tv);
                        tm_user[e] = c.user_word;
                    end else begin
                        tm_kind[e] = EK_FRAME;
                    end
                    tm_stamp[e] = stamp_ctr;
                    stamp_ctr++;
                    push_beat(RES_ACK, handle_ctr, 32'd0, ST_OK, 1'b1);
                    handle_ctr++;
                end
            end
            FUNC_REMOVE: begin
                e = find_entry(c.task_handle);
                if (e < 0) begin
                    push_beat(RES_ACK, c.task_handle, 32'd0, ST_NOT_FOUND, 1'b1);
                end else begin
                    push_beat(RES_ACK, c.task_handle,
                              tm_kind[e] == EK_ONESHOT ? tm_user[e] : 32'd0, ST_OK, 1'b1);
                    tm_valid[e] = 1'b0;
                end
            end
            FUNC_RESCHED: begin
                e = find_entry(c.task_handle);
                if (e < 0) begin
                    push_beat(RES_ACK, c.task_handle, 32'd0, ST_NOT_FOUND, 1'b1);
                end else begin
                    if (tm_kind[e] == EK_PERIODIC) begin
                        tm_period[e] = tv == 0 ? 32'd1 : tv;
                    end else if (tm_kind[e] == EK_ONESHOT) begin
                        tm_due[e] = longint'(tv);
                        tm_stamp[e] = stamp_ctr;
                        stamp_ctr++;
                    end
                    push_beat(RES_ACK, c.task_handle, 32'd0, ST_OK, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report(string what, t_out_beat got, t_out_beat want);
        errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // result side: stall driver and checker
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall = 1'b1;
            stall_left--;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            t_out_beat want;
            stall_left = quiet ? 0 : $urandom_range(0, 6);
            if (pending_beats.size() == 0) begin
                report("unexpected beat", o_out_beat, '0);
            end else begin
                want = pending_beats.pop_front();
                if (o_out_beat.kind != want.kind) report("kind", o_out_beat, want);
                if (o_out_beat.fired_handle != want.fired_handle)
                    report("handle", o_out_beat, want);
                if (o_out_beat.argument != want.argument) report("argument", o_out_beat, want);
                if (o_out_beat.status != want.status) report("status", o_out_beat, want);
                if (o_out_beat.last != want.last) report("last", o_out_beat, want);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WD_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // command side; called at a falling edge, returns at one
    task automatic send_cmd(logic [2:0] f, logic [30:0] tv, logic [15:0] h, logic [31:0] u);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_beat.func = f;
        i_in_beat.time_value = tv;
        i_in_beat.task_handle = h;
        i_in_beat.user_word = u;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_command(i_in_beat);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (pending_beats.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [15:0] live_handle();
        int idx[$];
        for (int i = 0; i < ENTRIES; i++) if (tm_valid[i]) idx = {idx, i};
        if (idx.size() == 0) return 16'($urandom);
        return tm_handle[idx[$urandom_range(0, idx.size() - 1)]];
    endfunction

    task automatic test_commands();
        send_cmd(FUNC_ADD_PER, 31'd0, 16'h0000, 32'h0000_0000);
        send_cmd(FUNC_ADD_PER, 31'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(FUNC_ADD_ONE, 31'd5, 16'h0000, 32'hFFFF_FFFF);
        send_cmd(FUNC_ADD_ONE, 31'h7FFF_FFFF, 16'hFFFF, 32'hA5A5_5A5A);
        send_cmd(FUNC_ADD_FRAME, 31'd0, 16'h0000, 32'h0);
        send_cmd(FUNC_RESCHED, 31'd0, 16'd0, 32'h0);
        send_cmd(FUNC_RESCHED, 31'd3, 16'd2, 32'h0);
        send_cmd(FUNC_RESCHED, 31'd9, 16'd4, 32'h0);
        send_cmd(FUNC_RESCHED, 31'd9, 16'hFFFF, 32'h0);
        send_cmd(3'd6, 31'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(3'd7, 31'd0, 16'd0, 32'd0);
        send_cmd(FUNC_TICK, 31'd4, 16'd0, 32'd0);
        send_cmd(FUNC_REMOVE, 31'd0, 16'd3, 32'd0);
        send_cmd(FUNC_REMOVE, 31'd0, 16'd1, 32'd0);
        send_cmd(FUNC_REMOVE, 31'd0, 16'd1, 32'd0);
        drain();
    endtask

    task automatic test_ties();
        send_cmd(FUNC_ADD_ONE, 31'd2, 16'd0, 32'h1111_1111);
        send_cmd(FUNC_ADD_ONE, 31'd2, 16'd0, 32'h2222_2222);
        send_cmd(FUNC_ADD_FRAME, 31'd0, 16'd0, 32'd0);
        send_cmd(FUNC_TICK, 31'd3, 16'd0, 32'd0);
        drain();
    endtask

    task automatic test_full_table();
        for (int i = 0; i < ENTRIES + 2; i++)
            send_cmd(FUNC_ADD_ONE, 31'(100 + i), 16'd0, $urandom);
        drain();
        for (int i = 0; i < ENTRIES; i++) send_cmd(FUNC_REMOVE, 31'd0, live_handle(), 32'd0);
        drain();
    endtask

    task automatic test_deferred();
        logic [15:0] h;
        h = handle_ctr;
        send_cmd(FUNC_ADD_PER, 31'd1, 16'd0, 32'd0);
        send_cmd(FUNC_TICK, 31'd150, 16'd0, 32'd0);
        send_cmd(FUNC_TICK, 31'd0, 16'd0, 32'd0);
        send_cmd(FUNC_TICK, 31'h7FFF_FFFF, 16'd0, 32'd0);
        send_cmd(FUNC_TICK, 31'h7FFF_FFFF, 16'd0, 32'd0);
        send_cmd(FUNC_TICK, 31'h7FFF_FFFF, 16'd0, 32'd0);
        send_cmd(FUNC_REMOVE, 31'd0, h, 32'd0);
        drain();
    endtask

    task automatic test_random();
        int          sel;
        logic [30:0] tv;
        logic [15:0] h;
        for (int n = 0; n < 100; n++) begin
            if (n % 40 == 20) quiet = 1'b1;
            if (n % 40 == 30) quiet = 1'b0;
            sel = $urandom_range(0, 99);
            tv = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 40));
            h = ($urandom_range(0, 5) == 0) ? 16'($urandom) : live_handle();
            if (sel < 22)
                send_cmd(FUNC_TICK,
                         $urandom_range(0, 9) == 0 ? 31'($urandom) : 31'($urandom_range(0, 15)),
                         16'($urandom), $urandom);
            else if (sel < 34) send_cmd(FUNC_ADD_PER, tv, 16'($urandom), $urandom);
            else if (sel < 48) send_cmd(FUNC_ADD_ONE, tv, 16'($urandom), $urandom);
            else if (sel < 56) send_cmd(FUNC_ADD_FRAME, tv, 16'($urandom), $urandom);
            else if (sel < 74) send_cmd(FUNC_REMOVE, tv, h, $urandom);
            else if (sel < 95) send_cmd(FUNC_RESCHED, tv, h, $urandom);
            else send_cmd(3'($urandom_range(6, 7)), tv, h, $urandom);
            if (n == 50) drain();
        end
        quiet = 1'b0;
        drain();
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) tm_valid[i] = 1'b0;
        handle_ctr = '0;
        stamp_ctr = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_commands();
        test_ties();
        test_full_table();
        test_deferred();
        test_random();
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending_beats.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

@@ timed_task_scheduler.f @@
+incdir+hw/rtl
hw/rtl/tts_pkg.sv
hw/rtl/tts_ram.sv
hw/rtl/timed_task_scheduler.sv
dv/tb.sv
